FILE: rtl/pcr_pkg.sv
// Package for the population cost rank core: constants and the sequencer state type.
package pcr_pkg;

  localparam int POP_MAX_DEF = 32;
  localparam int DIM_MAX_DEF = 64;

  localparam int SAMPLE_W   = 16;
  localparam int COST_W     = 48;
  localparam int OIDX_W     = 5;
  localparam int ROWLEN_W   = 7;
  localparam int POPCNT_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [ROWLEN_W-1:0] ROWLEN_RST = ROWLEN_W'(50);
  localparam logic [POPCNT_W-1:0] POPCNT_RST = POPCNT_W'(20);

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POPULATION_COUNT = CFG_IDX_W'(1);

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_CUR,
    ST_DIFF,
    ST_SQ_D,
    ST_T1,
    ST_SQ_E,
    ST_ACC,
    ST_RD,
    ST_CMP,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/population_cost_rank_core.sv
// Rosenbrock row cost over a shared multiplier, then ranked output by repeated minimum search.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_sample_i
//  out     | output    | out_valid_o/out_stall_i | out_cost_o, out_original_index_o, out_last_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// First sample of a row is only stored. Each further sample runs SQ_CUR, DIFF, SQ_D, T1,
// SQ_E and ACC: one pass of the 32x32 multiplier for cur^2, d^2 and (cur-1)^2 plus
// difference, scale and add steps. Ranking: per result a scan over the cost memory (one
// read port), a read and a compare per row of the population, then the output state.
// Reset clears control state only; the cost memory holds no reset value.
// A stalled result holds the sequencer; no input is taken until the last result goes.
module population_cost_rank_core #(
  parameter int POP_MAX = pcr_pkg::POP_MAX_DEF,
  parameter int DIM_MAX = pcr_pkg::DIM_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [pcr_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pcr_pkg::COST_W-1:0]        out_cost_o,
  output logic [pcr_pkg::OIDX_W-1:0]        out_original_index_o,
  output logic                              out_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int IW  = $clog2(POP_MAX);
  localparam int PW  = $clog2(POP_MAX + 1);
  localparam int LW  = $clog2(DIM_MAX + 1);
  localparam int PCW = (PW > pcr_pkg::POPCNT_W) ? PW : pcr_pkg::POPCNT_W;
  localparam int LCW = (LW > pcr_pkg::ROWLEN_W) ? LW : pcr_pkg::ROWLEN_W;
  localparam int OXW = (IW > pcr_pkg::OIDX_W) ? IW : pcr_pkg::OIDX_W;
  localparam int CW  = pcr_pkg::COST_W;
  localparam int SW  = pcr_pkg::SAMPLE_W;

  pcr_pkg::state_e state_q, state_d;

  logic [pcr_pkg::ROWLEN_W-1:0] row_len_q, row_len_d;
  logic [pcr_pkg::POPCNT_W-1:0] pop_cnt_q, pop_cnt_d;
  logic [CW-1:0]  acc_q, acc_d;
  logic [SW-1:0]  prev_q, prev_d;
  logic [SW-1:0]  nxt_q, nxt_d;
  logic [LW-1:0]  elem_q, elem_d;
  logic [PW-1:0]  row_q, row_d;
  logic [63:0]    prod_q, prod_d;
  logic [31:0]    ad_q, ad_d;
  logic [33:0]    term_q, term_d;
  logic [IW-1:0]  scan_q, scan_d;
  logic [PW-1:0]  rank_q, rank_d;
  logic           have_best_q, have_best_d;
  logic [CW-1:0]  best_cost_q, best_cost_d;
  logic [IW-1:0]  best_idx_q, best_idx_d;
  logic [POP_MAX-1:0] used_q, used_d;

  logic [CW-1:0] cost_mem [POP_MAX];
  logic [CW-1:0] rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;

  // effective (clamped) lengths
  logic [LCW-1:0] len_ext;
  logic [LW-1:0]  len_eff;
  logic [PCW-1:0] pop_ext;
  logic [PW-1:0]  pop_eff;

  always_comb begin
    len_ext = LCW'(row_len_q);
    if (len_ext < LCW'(2)) len_ext = LCW'(2);
    if (len_ext > LCW'(DIM_MAX)) len_ext = LCW'(DIM_MAX);
    len_eff = len_ext[LW-1:0];
    pop_ext = PCW'(pop_cnt_q);
    if (pop_ext < PCW'(1)) pop_ext = PCW'(1);
    if (pop_ext > PCW'(POP_MAX)) pop_ext = PCW'(POP_MAX);
    pop_eff = pop_ext[PW-1:0];
  end

  // shared multiplier and its operand select
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic signed [17:0] cur_s, e_s;
  logic [16:0] cur_abs, e_abs;
  logic signed [32:0] d_s;
  logic [68:0] scaled;
  logic [CW+1:0] sum;
  logic [LW-1:0] elem_inc;
  logic [PW-1:0] row_inc;
  logic [OXW-1:0] oidx_wide;
  logic cfg_we;

  always_comb begin
    cur_s   = 18'(signed'(prev_q));
    cur_abs = cur_s[17] ? 17'(-cur_s) : cur_s[16:0];
    e_s     = cur_s - 18'sd4096;
    e_abs   = e_s[17] ? 17'(-e_s) : e_s[16:0];
    d_s     = (33'(signed'(nxt_q)) <<< 12) - signed'({1'b0, prod_q[31:0]});
    case (state_q)
      pcr_pkg::ST_SQ_D: mul_a = ad_q;
      pcr_pkg::ST_SQ_E: mul_a = 32'(e_abs);
      default:          mul_a = 32'(cur_abs);
    endcase
    mul_p  = 64'(mul_a) * 64'(mul_a);
    // 100 = 64 + 32 + 4
    scaled = (69'(prod_q) << 6) + (69'(prod_q) << 5) + (69'(prod_q) << 2);
    sum    = (CW+2)'(acc_q) + (CW+2)'(term_q) + (CW+2)'(prod_q[63:12]);
  end

  always_comb begin
    state_d     = state_q;
    row_len_d   = row_len_q;
    pop_cnt_d   = pop_cnt_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    elem_d      = elem_q;
    row_d       = row_q;
    prod_d      = prod_q;
    ad_d        = ad_q;
    term_d      = term_q;
    scan_d      = scan_q;
    rank_d      = rank_q;
    have_best_d = have_best_q;
    best_cost_d = best_cost_q;
    best_idx_d  = best_idx_q;
    used_d      = used_q;
    mem_we      = 1'b0;
    mem_waddr   = row_q[IW-1:0];
    mem_wdata   = acc_q;
    elem_inc    = elem_q + LW'(1);
    row_inc     = row_q + PW'(1);
    // a pending register write holds off the sample request
    in_stall_o  = (state_q != pcr_pkg::ST_IDLE) || cfg_valid_i;
    cfg_ready_o = (state_q == pcr_pkg::ST_IDLE);
    out_valid_o = (state_q == pcr_pkg::ST_OUT);
    cfg_we      = cfg_valid_i && cfg_ready_o;

    case (state_q)
      pcr_pkg::ST_IDLE: begin
        if (cfg_we) begin
          if (cfg_index_i == pcr_pkg::CFG_ROW_LENGTH ||
              cfg_index_i == pcr_pkg::CFG_POPULATION_COUNT) begin
            if (cfg_index_i == pcr_pkg::CFG_ROW_LENGTH) row_len_d = cfg_data_i;
            else pop_cnt_d = pcr_pkg::POPCNT_W'(cfg_data_i);
            acc_d  = '0;
            elem_d = '0;
            row_d  = '0;
          end
        end else if (in_valid_i) begin
          prev_d = in_sample_i;
          nxt_d  = in_sample_i;
          if (elem_q == '0) begin
            elem_d = LW'(1);
          end else begin
            prev_d  = prev_q;
            state_d = pcr_pkg::ST_SQ_CUR;
          end
        end
      end
      pcr_pkg::ST_SQ_CUR: begin
        prod_d  = mul_p;
        state_d = pcr_pkg::ST_DIFF;
      end
      pcr_pkg::ST_DIFF: begin
        ad_d    = d_s[32] ? 32'(-d_s) : d_s[31:0];
        state_d = pcr_pkg::ST_SQ_D;
      end
      pcr_pkg::ST_SQ_D: begin
        prod_d  = mul_p;
        state_d = pcr_pkg::ST_T1;
      end
      pcr_pkg::ST_T1: begin
        term_d  = 34'(scaled[69-1:36]);
        state_d = pcr_pkg::ST_SQ_E;
      end
      pcr_pkg::ST_SQ_E: begin
        prod_d  = mul_p;
        state_d = pcr_pkg::ST_ACC;
      end
      pcr_pkg::ST_ACC: begin
        acc_d   = (sum > (CW+2)'(pcr_pkg::COST_MAX)) ? pcr_pkg::COST_MAX : sum[CW-1:0];
        prev_d  = nxt_q;
        elem_d  = elem_inc;
        state_d = pcr_pkg::ST_IDLE;
        if (elem_inc == len_eff) begin
          mem_we    = 1'b1;
          mem_wdata = acc_d;
          acc_d     = '0;
          elem_d    = '0;
          row_d     = row_inc;
          if (row_inc == pop_eff) begin
            row_d       = '0;
            scan_d      = '0;
            rank_d      = '0;
            have_best_d = 1'b0;
            used_d      = '0;
            state_d     = pcr_pkg::ST_RD;
          end
        end
      end
      pcr_pkg::ST_RD: begin
        state_d = pcr_pkg::ST_CMP;
      end
      pcr_pkg::ST_CMP: begin
        // strict compare in ascending scan keeps the lower row first on a tie
        if (!used_q[scan_q] && (!have_best_q || rdata_q < best_cost_q)) begin
          have_best_d = 1'b1;
          best_cost_d = rdata_q;
          best_idx_d  = scan_q;
        end
        if (PW'(scan_q) == pop_eff - PW'(1)) begin
          state_d = pcr_pkg::ST_OUT;
        end else begin
          scan_d  = scan_q + IW'(1);
          state_d = pcr_pkg::ST_RD;
        end
      end
      pcr_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          used_d[best_idx_q] = 1'b1;
          rank_d      = rank_q + PW'(1);
          scan_d      = '0;
          have_best_d = 1'b0;
          state_d     = (rank_q == pop_eff - PW'(1)) ? pcr_pkg::ST_IDLE : pcr_pkg::ST_RD;
        end
      end
      default: state_d = pcr_pkg::ST_IDLE;
    endcase
  end

  assign oidx_wide            = OXW'(best_idx_q);
  assign out_cost_o           = best_cost_q;
  assign out_original_index_o = oidx_wide[pcr_pkg::OIDX_W-1:0];
  assign out_last_o           = (rank_q == pop_eff - PW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcr_pkg::ST_IDLE;
      row_len_q   <= pcr_pkg::ROWLEN_RST;
      pop_cnt_q   <= pcr_pkg::POPCNT_RST;
      acc_q       <= '0;
      prev_q      <= '0;
      elem_q      <= '0;
      row_q       <= '0;
      scan_q      <= '0;
      rank_q      <= '0;
      have_best_q <= 1'b0;
      used_q      <= '0;
    end else begin
      state_q     <= state_d;
      row_len_q   <= row_len_d;
      pop_cnt_q   <= pop_cnt_d;
      acc_q       <= acc_d;
      prev_q      <= prev_d;
      elem_q      <= elem_d;
      row_q       <= row_d;
      scan_q      <= scan_d;
      rank_q      <= rank_d;
      have_best_q <= have_best_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q       <= nxt_d;
    prod_q      <= prod_d;
    ad_q        <= ad_d;
    term_q      <= term_d;
    best_cost_q <= best_cost_d;
    best_idx_q  <= best_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cost_mem[mem_waddr] <= mem_wdata;
    rdata_q <= cost_mem[scan_q];
  end

  // results only while input is held off
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result presented while input open");

  // a write to row length or population count abandons the partial row and population
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == pcr_pkg::CFG_ROW_LENGTH ||
     cfg_index_i == pcr_pkg::CFG_POPULATION_COUNT))
    |=> (elem_q == '0 && row_q == '0 && acc_q == '0))
    else $error("register write did not clear run state");

  // every presented result refers to a row not yet emitted
  a_best_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (have_best_q && !used_q[best_idx_q]))
    else $error("result repeats an emitted row");

  // emitted count never reaches the population before the run ends
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rank_q < pop_eff))
    else $error("rank beyond population");

endmodule
